/* rtl/arithmetic_expression_lexer_core_assert.svh */
// Assertion macros shared by the lexer core modules.
`ifndef ARITHMETIC_EXPRESSION_LEXER_CORE_ASSERT_SVH
`define ARITHMETIC_EXPRESSION_LEXER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define AEL_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define AEL_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/ael_pkg.sv */
// Types and constants shared by the arithmetic expression lexer modules.
`default_nettype none
package ael_pkg;

    localparam int unsigned KIND_W  = 4;
    localparam int unsigned VALUE_W = 31;
    localparam int unsigned ERR_W   = 2;

    localparam logic [KIND_W-1:0] KIND_INT   = 4'd0;
    localparam logic [KIND_W-1:0] KIND_D     = 4'd1;
    localparam logic [KIND_W-1:0] KIND_L     = 4'd2;
    localparam logic [KIND_W-1:0] KIND_H     = 4'd3;
    localparam logic [KIND_W-1:0] KIND_PLUS  = 4'd4;
    localparam logic [KIND_W-1:0] KIND_MINUS = 4'd5;
    localparam logic [KIND_W-1:0] KIND_DIV   = 4'd6;
    localparam logic [KIND_W-1:0] KIND_MUL   = 4'd7;
    localparam logic [KIND_W-1:0] KIND_OPEN  = 4'd8;
    localparam logic [KIND_W-1:0] KIND_CLOSE = 4'd9;
    localparam logic [KIND_W-1:0] KIND_END   = 4'd10;
    localparam logic [KIND_W-1:0] KIND_NONE  = 4'd15;

    localparam logic [ERR_W-1:0] ERR_NONE = 2'd0;
    localparam logic [ERR_W-1:0] ERR_CHAR = 2'd1;
    localparam logic [ERR_W-1:0] ERR_BIG  = 2'd2;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;

    localparam logic [3:0] DEC_BASE = 4'd10;

    typedef struct packed {
        logic [KIND_W-1:0]  token_kind;
        logic [VALUE_W-1:0] int_value;
        logic [ERR_W-1:0]   error_code;
        logic               last_of_item;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } lex_push_t;

endpackage
`default_nettype wire

/* rtl/ael_lexer.sv */
// Lexer state and single-pass token decode for one character transaction.
`default_nettype none
`include "arithmetic_expression_lexer_core_assert.svh"
module ael_lexer
    import ael_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       item_fire,
    input  wire logic [7:0] char_code,
    input  wire logic       end_of_text,
    output lex_push_t       push
);

    logic [VALUE_W-1:0] pending_value_reg, pending_value_next;
    logic               digits_pending_reg, digits_pending_next;
    logic               value_overflowed_reg, value_overflowed_next;
    logic               error_hold_reg, error_hold_next;

    logic [KIND_W-1:0]  op_kind;
    logic [VALUE_W+3:0] grown;
    result_t            flush_res;
    result_t            r0, r1;
    logic [1:0]         n;

    always_comb begin
        case (char_code)
            "d", "D": op_kind = KIND_D;
            "l", "L": op_kind = KIND_L;
            "h", "H": op_kind = KIND_H;
            "+":      op_kind = KIND_PLUS;
            "-":      op_kind = KIND_MINUS;
            "/":      op_kind = KIND_DIV;
            "*":      op_kind = KIND_MUL;
            "(":      op_kind = KIND_OPEN;
            ")":      op_kind = KIND_CLOSE;
            default:  op_kind = KIND_NONE;
        endcase
    end

    assign grown = {4'd0, pending_value_reg} * {{(VALUE_W){1'b0}}, DEC_BASE}
                 + {{(VALUE_W){1'b0}}, char_code[3:0]};

    always_comb begin
        flush_res = '0;
        flush_res.token_kind = KIND_INT;
        if (value_overflowed_reg) begin
            flush_res.error_code = ERR_BIG;
        end else begin
            flush_res.int_value = pending_value_reg;
        end
    end

    always_comb begin
        pending_value_next    = pending_value_reg;
        digits_pending_next   = digits_pending_reg;
        value_overflowed_next = value_overflowed_reg;
        error_hold_next       = error_hold_reg;
        r0 = '0;
        r1 = '0;
        n  = 2'd0;
        if (end_of_text) begin
            if (!error_hold_reg && digits_pending_reg) begin
                r0 = flush_res;
                r1.token_kind = KIND_END;
                n = 2'd2;
            end else begin
                r0.token_kind = KIND_END;
                n = 2'd1;
            end
            pending_value_next    = '0;
            digits_pending_next   = 1'b0;
            value_overflowed_next = 1'b0;
            error_hold_next       = 1'b0;
        end else if (error_hold_reg) begin
            n = 2'd0;
        end else if (char_code inside {[CH_ZERO:CH_NINE]}) begin
            if (!value_overflowed_reg) begin
                if (grown[VALUE_W+3:VALUE_W] != 4'd0) begin
                    value_overflowed_next = 1'b1;
                end else begin
                    pending_value_next = grown[VALUE_W-1:0];
                end
            end
            digits_pending_next = 1'b1;
        end else if (char_code inside {CH_SPACE, CH_TAB, CH_LF}) begin
            n = 2'd0;
        end else begin
            pending_value_next    = '0;
            digits_pending_next   = 1'b0;
            value_overflowed_next = 1'b0;
            if (op_kind == KIND_NONE) begin
                r0.token_kind = KIND_INT;
                r0.error_code = ERR_CHAR;
                n = 2'd1;
                error_hold_next = 1'b1;
            end else if (digits_pending_reg && value_overflowed_reg) begin
                r0.token_kind = KIND_INT;
                r0.error_code = ERR_BIG;
                n = 2'd1;
                error_hold_next = 1'b1;
            end else if (digits_pending_reg) begin
                r0 = flush_res;
                r1.token_kind = op_kind;
                n = 2'd2;
            end else begin
                r0.token_kind = op_kind;
                n = 2'd1;
            end
        end
        if (n == 2'd1) begin
            r0.last_of_item = 1'b1;
        end
        if (n == 2'd2) begin
            r1.last_of_item = 1'b1;
        end
    end

    always_comb begin
        push.first  = r0;
        push.second = r1;
        push.count  = item_fire ? n : 2'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_value_reg    <= '0;
            digits_pending_reg   <= 1'b0;
            value_overflowed_reg <= 1'b0;
            error_hold_reg       <= 1'b0;
        end else if (item_fire) begin
            pending_value_reg    <= pending_value_next;
            digits_pending_reg   <= digits_pending_next;
            value_overflowed_reg <= value_overflowed_next;
            error_hold_reg       <= error_hold_next;
        end
    end

    `AEL_ASSERT_SAME(a_hold_no_number, aclk, aresetn, error_hold_reg,
        !digits_pending_reg && !value_overflowed_reg && pending_value_reg == '0,
        "number state live while error hold set")
    `AEL_ASSERT_NEXT(a_end_clears, aclk, aresetn, item_fire && end_of_text,
        !error_hold_reg && !digits_pending_reg && pending_value_reg == '0,
        "end transaction did not clear lexer state")

endmodule
`default_nettype wire

/* rtl/ael_result_fifo.sv */
// Four-entry result queue taking up to two results and giving one per cycle while out_ready is high.
`default_nettype none
`include "arithmetic_expression_lexer_core_assert.svh"
module ael_result_fifo
    import ael_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire lex_push_t push,
    output logic           room_for_two,
    output logic           out_valid,
    input  wire logic      out_ready,
    output result_t        out_data
);

    localparam int unsigned DEPTH = 4;
    localparam int unsigned PTR_W = $clog2(DEPTH);

    result_t            mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]     count_reg, count_next;
    logic               pop;

    assign out_valid    = count_reg != '0;
    assign out_data     = mem[rd_ptr_reg];
    assign pop          = out_valid && out_ready;
    assign room_for_two = count_reg <= (PTR_W+1)'(DEPTH - 2);

    always_comb begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push.count);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + (PTR_W+1)'(push.count) - (PTR_W+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            mem[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2) begin
            mem[wr_ptr_reg + PTR_W'(1)] <= push.second;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `AEL_ASSERT_SAME(a_push_fits, aclk, aresetn, push.count != 2'd0,
        room_for_two, "push into queue without room for two results")
    `AEL_ASSERT_SAME(a_ptr_count, aclk, aresetn, 1'b1,
        PTR_W'(wr_ptr_reg - rd_ptr_reg) == count_reg[PTR_W-1:0],
        "queue pointers disagree with count")

endmodule
`default_nettype wire

/* rtl/arithmetic_expression_lexer_core.sv */
// A transaction is registered in the input stage, decoded from that register, and its results
// are written into the result queue. Throughput: one character transaction per cycle while the
// queue has room for two results; a transaction's two results leave the four-entry queue one at a time.
// Decode advances only while the queue has room for two results.
// Reset: synchronous active-low aresetn clears lexer state, input stage and result queue.
`default_nettype none
`include "arithmetic_expression_lexer_core_assert.svh"
module arithmetic_expression_lexer_core
    import ael_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [7:0]         s_char_code,
    input  wire logic               s_end_of_text,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [KIND_W-1:0]       m_token_kind,
    output logic [VALUE_W-1:0]      m_int_value,
    output logic [ERR_W-1:0]        m_error_code,
    output logic                    m_last_of_item
);

    logic       in_valid_reg;
    logic [7:0] in_char_reg;
    logic       in_eot_reg;
    logic       room_for_two;
    logic       commit;
    lex_push_t  push;
    result_t    out_data;

    assign commit  = in_valid_reg && room_for_two;
    assign s_ready = !in_valid_reg || commit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_char_reg <= s_char_code;
            in_eot_reg  <= s_end_of_text;
        end
    end

    ael_lexer u_lexer (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .item_fire   (commit),
        .char_code   (in_char_reg),
        .end_of_text (in_eot_reg),
        .push        (push)
    );

    ael_result_fifo u_result_fifo (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .push         (push),
        .room_for_two (room_for_two),
        .out_valid    (m_valid),
        .out_ready    (m_ready),
        .out_data     (out_data)
    );

    assign m_token_kind   = out_data.token_kind;
    assign m_int_value    = out_data.int_value;
    assign m_error_code   = out_data.error_code;
    assign m_last_of_item = out_data.last_of_item;

    `AEL_ASSERT_NEXT(a_stage_holds, aclk, aresetn, in_valid_reg && !commit,
        in_valid_reg && $stable(in_char_reg) && $stable(in_eot_reg),
        "stalled input stage lost its transaction")

endmodule
`default_nettype wire
